[rtl/core/dnpu_pkg.sv]
package dnpu_pkg;

    // operand width default, the operand field is always 32 bits on the port
    localparam int DNPU_VALUE_W = 32;

    // field widths of the stream payloads
    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int VERDICT_W = 2;
    localparam int NUM_W     = 34;

    // packed payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((MODE_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VERDICT_W + NUM_W + 1 + 7) / 8) * 8;

    // decimal radix for the digit loops
    localparam int RADIX = 10;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PARITY = 3'd0,
        MODE_PRIME  = 3'd1,
        MODE_PALIN  = 3'd2,
        MODE_SIGN   = 3'd3,
        MODE_REV    = 3'd4,
        MODE_SUM    = 3'd5
    } mode_t;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_FALSE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TRUE  = 2'd1;
    localparam logic [VERDICT_W-1:0] SIGN_POS      = 2'd0;
    localparam logic [VERDICT_W-1:0] SIGN_NEG      = 2'd1;
    localparam logic [VERDICT_W-1:0] SIGN_ZERO     = 2'd2;

endpackage

[rtl/core/dnpu_divider.sv]
module dnpu_divider #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       ge;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/decimal_number_property_unit.sv]
// channel   | dir | fields (tdata, lowest bit first)              | width
// s_axis    | in  | mode[2:0], value[34:3], zero pad [39:35]       | 40
// m_axis    | out | verdict[1:0], number[35:2], invalid[36], pad   | 40
//
// parity, sign and invalid modes go from the input transfer to ST_DONE, then to the output register
// prime test: up to floor(sqrt(n)) - 1 trial divisions, each run on the divider
// digit modes: ST_DIGIT_DIV then ST_DIGIT_ACC for each decimal digit, then ST_DONE
// trial division runs on the bit-serial divider, digits use a multiply by 1/10
// rst_n clears control state asynchronously; no memory, no clearing pass
// input is taken only while the sequencer is idle; a result waiting on
// m_axis does not block the next input transfer, only the next result
module decimal_number_property_unit
    import dnpu_pkg::*;
#(
    parameter int VALUE_WIDTH = DNPU_VALUE_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // mode, value, pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // verdict, number, invalid, pad
);

    localparam int W = VALUE_WIDTH;

    // ceil(2^35 / 10), exact quotient by ten for any 32-bit operand
    localparam logic [31:0] TEN_RECIP = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME_CHECK,
        ST_PRIME_WAIT,
        ST_DIGIT_DIV,
        ST_DIGIT_ACC,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [W-1:0]       n_reg, n_next;       // operand as taken, never negative in the loops
    logic [W-1:0]       t_reg, t_next;       // remaining digits
    logic [W-1:0]       q_reg, q_next;       // remaining digits over ten
    logic [W-1:0]       d_reg, d_next;       // trial divisor
    logic [W-1:0]       sq_reg, sq_next;     // d squared
    logic [NUM_W-1:0]   acc_reg, acc_next;   // reversal or digit sum
    logic               start_reg, start_next;

    logic [VERDICT_W-1:0] res_verdict_reg, res_verdict_next;
    logic [NUM_W-1:0]     res_number_reg, res_number_next;
    logic                 res_invalid_reg, res_invalid_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0] out_verdict_reg, out_verdict_next;
    logic [NUM_W-1:0]     out_number_reg, out_number_next;
    logic                 out_invalid_reg, out_invalid_next;

    // input fields
    logic [MODE_W-1:0]  in_mode;
    logic [VALUE_W-1:0] in_value;
    logic [W-1:0]       op;
    logic               op_neg;
    logic               op_zero;
    logic               op_le1;

    // trial divider
    logic         div_done;
    logic [W-1:0] div_rem;

    // divide by ten
    logic [31:0]  t_wide;
    logic [63:0]  ten_prod;
    logic [W-1:0] ten_quo;
    logic [W-1:0] digit;

    logic [NUM_W-1:0] acc_step;

    assign in_mode  = s_axis_tdata[MODE_W-1:0];
    assign in_value = s_axis_tdata[MODE_W+VALUE_W-1:MODE_W];
    assign op       = in_value[W-1:0];
    assign op_neg   = op[W-1];
    assign op_zero  = (op == '0);
    assign op_le1   = op_neg || op_zero || (op == W'(1));

    assign s_axis_tready = (state_reg == ST_IDLE);

    // trial division of the operand by the current divisor
    dnpu_divider #(
        .W (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // quotient by ten through a constant multiply, lowest digit from the registered quotient in ST_DIGIT_ACC
    assign t_wide   = 32'(t_reg);
    assign ten_prod = 64'(t_wide) * 64'(TEN_RECIP);
    assign ten_quo  = W'(ten_prod[63:35]);
    assign digit    = t_reg - W'(q_reg * RADIX);

    // next accumulator value: add the digit, or shift left one decimal place first
    always_comb
    begin
        if (mode_reg == MODE_SUM)
            acc_step = acc_reg + NUM_W'(digit);
        else
            acc_step = (acc_reg << 3) + (acc_reg << 1) + NUM_W'(digit);
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        n_next           = n_reg;
        t_next           = t_reg;
        q_next           = q_reg;
        d_next           = d_reg;
        sq_next          = sq_reg;
        acc_next         = acc_reg;
        start_next       = 1'b0;
        res_verdict_next = res_verdict_reg;
        res_number_next  = res_number_reg;
        res_invalid_next = res_invalid_reg;
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        out_number_next  = out_number_reg;
        out_invalid_next = out_invalid_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next        = in_mode;
                    n_next           = op;
                    t_next           = op;
                    d_next           = W'(2);
                    sq_next          = W'(4);
                    acc_next         = '0;
                    res_verdict_next = VERDICT_FALSE;
                    res_number_next  = '0;
                    res_invalid_next = 1'b0;
                    state_next       = ST_DONE;
                    case (in_mode)
                        MODE_PARITY:
                            res_verdict_next = {1'b0, op[0]};
                        MODE_SIGN:
                            res_verdict_next = op_neg ? SIGN_NEG :
                                               (op_zero ? SIGN_ZERO : SIGN_POS);
                        MODE_PRIME:
                        begin
                            if (!op_le1)
                                state_next = ST_PRIME_CHECK;
                        end
                        MODE_PALIN, MODE_REV, MODE_SUM:
                        begin
                            // zero reads the same both ways, negatives give nothing
                            if (op_neg || op_zero)
                            begin
                                if (in_mode == MODE_PALIN && op_zero)
                                    res_verdict_next = VERDICT_TRUE;
                            end
                            else
                                state_next = ST_DIGIT_DIV;
                        end
                        default:
                            res_invalid_next = 1'b1;
                    endcase
                end
            end

            ST_PRIME_CHECK:
            begin
                if (sq_reg > n_reg)
                begin
                    res_verdict_next = VERDICT_TRUE;
                    state_next       = ST_DONE;
                end
                else
                begin
                    start_next = 1'b1;
                    state_next = ST_PRIME_WAIT;
                end
            end

            ST_PRIME_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        res_verdict_next = VERDICT_FALSE;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        // (d + 1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + {d_reg[W-2:0], 1'b1};
                        state_next = ST_PRIME_CHECK;
                    end
                end
            end

            ST_DIGIT_DIV:
            begin
                q_next     = ten_quo;
                state_next = ST_DIGIT_ACC;
            end

            ST_DIGIT_ACC:
            begin
                acc_next = acc_step;
                t_next   = q_reg;
                if (q_reg == '0)
                begin
                    if (mode_reg == MODE_PALIN)
                        res_verdict_next = (acc_step == NUM_W'(n_reg)) ?
                                           VERDICT_TRUE : VERDICT_FALSE;
                    else
                        res_number_next = acc_step;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_DIGIT_DIV;
            end

            ST_DONE:
            begin
                // move into the output register once it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = res_verdict_reg;
                    out_number_next  = res_number_reg;
                    out_invalid_next = res_invalid_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        n_reg           <= n_next;
        t_reg           <= t_next;
        q_reg           <= q_next;
        d_reg           <= d_next;
        sq_reg          <= sq_next;
        acc_reg         <= acc_next;
        res_verdict_reg <= res_verdict_next;
        res_number_reg  <= res_number_next;
        res_invalid_reg <= res_invalid_next;
        out_verdict_reg <= out_verdict_next;
        out_number_reg  <= out_number_next;
        out_invalid_reg <= out_invalid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VERDICT_W - NUM_W - 1){1'b0}},
                            out_invalid_reg, out_number_reg, out_verdict_reg};

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dnpu_pkg::*;

    // the two mode codes that name no operation
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // idle windows, long receiver hold and the drain after the last result
    localparam int IDLE_PCT     = 9;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } operand_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [NUM_W-1:0]     number;
        logic                 invalid;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // mode, value, pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // verdict, number, invalid, pad

    operand_t operands_pending[$];
    outcome_t outcomes_due[$];

    int  errors = 0;
    int  operands_sent = 0;
    int  outcomes_seen = 0;
    int  mode_counts[8];
    bit  taken_in = 1'b0;
    bit  held_once = 1'b0;
    int  hold_left = 0;

    decimal_number_property_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // expected result of one operand, worked out at full precision
    function automatic outcome_t property_of(logic [MODE_W-1:0] mode,
                                             logic signed [VALUE_W-1:0] value);
        outcome_t            o;
        longint              v;
        longint unsigned     t;
        longint unsigned     rev;
        longint unsigned     total;
        longint unsigned     d;
        bit                  prime;
        o = '0;
        v = longint'(value);
        rev = 0;
        total = 0;
        // digit reversal and digit sum, both zero for zero and negatives
        if (v > 0)
        begin
            t = v;
            while (t > 0)
            begin
                rev = rev * 10 + t % 10;
                total = total + t % 10;
                t = t / 10;
            end
        end
        case (mode)
            MODE_PARITY: o.verdict = {1'b0, value[0]};
            MODE_PRIME:
            begin
                // values of one or less are never prime
                prime = (v > 1);
                t = v;
                for (d = 2; prime && d * d <= t; d++)
                    if (t % d == 0)
                        prime = 1'b0;
                o.verdict = prime ? VERDICT_TRUE : VERDICT_FALSE;
            end
            MODE_PALIN:
                o.verdict = (v >= 0 && rev == longint'(v)) ? VERDICT_TRUE : VERDICT_FALSE;
            MODE_SIGN:
                o.verdict = (v > 0) ? SIGN_POS : ((v < 0) ? SIGN_NEG : SIGN_ZERO);
            MODE_REV: o.number = rev[NUM_W-1:0];
            MODE_SUM: o.number = total[NUM_W-1:0];
            default:  o.invalid = 1'b1;
        endcase
        return o;
    endfunction

    task automatic queue_operand(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value);
        operand_t op;
        op.mode = mode;
        op.value = value;
        operands_pending.push_back(op);
    endtask

    // sender: a new transfer is offered at the falling edge once the last one went through
    always @(negedge clk)
    begin
        operand_t op;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || taken_in)
        begin
            // no idling while the quiet window of the sender is open
            if (operands_pending.size() > 0 &&
                ((operands_sent >= 900 && operands_sent < 1200) ||
                 $urandom_range(0, 99) >= IDLE_PCT))
            begin
                op = operands_pending.pop_front();
                s_axis_tdata  <= {{(IN_DATA_W - MODE_W - VALUE_W){1'b0}}, op.value, op.mode};
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold counted here, and a stall-free window
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!held_once && outcomes_seen >= HOLD_AT)
        begin
            // the sender keeps offering, so the block fills and stalls its input
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= (outcomes_seen >= 1000 && outcomes_seen < 1300) ||
                             ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on every input transfer, check every output transfer
    always @(posedge clk)
    begin
        operand_t op;
        outcome_t got;
        outcome_t want;
        taken_in <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            op.mode  = s_axis_tdata[MODE_W-1:0];
            op.value = s_axis_tdata[MODE_W+VALUE_W-1:MODE_W];
            outcomes_due.push_back(property_of(op.mode, op.value));
            mode_counts[op.mode] = mode_counts[op.mode] + 1;
            operands_sent = operands_sent + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.verdict = m_axis_tdata[VERDICT_W-1:0];
            got.number  = m_axis_tdata[VERDICT_W+NUM_W-1:VERDICT_W];
            got.invalid = m_axis_tdata[VERDICT_W+NUM_W];
            outcomes_seen = outcomes_seen + 1;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual %h",
                         $time, m_axis_tdata);
                errors = errors + 1;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (got.verdict !== want.verdict)
                begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d",
                             $time, want.verdict, got.verdict);
                    errors = errors + 1;
                end
                if (got.number !== want.number)
                begin
                    $display("%0t: number mismatch, expected %0d actual %0d",
                             $time, want.number, got.number);
                    errors = errors + 1;
                end
                if (got.invalid !== want.invalid)
                begin
                    $display("%0t: invalid flag mismatch, expected %0b actual %0b",
                             $time, want.invalid, got.invalid);
                    errors = errors + 1;
                end
            end
        end
    end

    // stimulus: directed corners, a full drain, then random operands
    initial
    begin
        int              n;
        int              len;
        int              k;
        int              digs[9];
        int              pick;
        logic [MODE_W-1:0] mode;
        longint          acc;
        logic signed [VALUE_W-1:0] val;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // parity of zero, of an odd negative and of the most negative value
        queue_operand(MODE_PARITY, 0);
        queue_operand(MODE_PARITY, -1);
        queue_operand(MODE_PARITY, VALUE_MIN);
        // prime: one or less is never prime, small and mid-size primes, a composite
        queue_operand(MODE_PRIME, 1);
        queue_operand(MODE_PRIME, 0);
        queue_operand(MODE_PRIME, -7);
        queue_operand(MODE_PRIME, 2);
        queue_operand(MODE_PRIME, 97);
        queue_operand(MODE_PRIME, 65521);
        queue_operand(MODE_PRIME, 91);
        // palindrome: zero is one, negatives never are
        queue_operand(MODE_PALIN, 0);
        queue_operand(MODE_PALIN, 12321);
        queue_operand(MODE_PALIN, -121);
        queue_operand(MODE_PALIN, 123);
        queue_operand(MODE_SIGN, VALUE_MAX);
        queue_operand(MODE_SIGN, VALUE_MIN);
        queue_operand(MODE_SIGN, 0);
        // reversal of the largest operand goes past 32 bits
        queue_operand(MODE_REV, VALUE_MAX);
        queue_operand(MODE_REV, -5);
        queue_operand(MODE_REV, 1200);
        queue_operand(MODE_SUM, 999999999);
        queue_operand(MODE_SUM, VALUE_MIN);
        queue_operand(MODE_SPARE_A, 12345);
        queue_operand(MODE_SPARE_B, -1);

        // stimulus waits here until every directed result is back
        while (operands_pending.size() > 0 || outcomes_due.size() > 0 || s_axis_tvalid)
            @(posedge clk);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = MODE_W'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                val = $urandom_range(0, 1000);
            end
            else if (pick < 40)
            begin
                val = VALUE_W'(($urandom_range(0, 1) == 0) ?
                               -$signed({1'b0, $urandom_range(1, 1000)}) :
                               $signed($urandom() | 32'h8000_0000));
            end
            else if (pick < 60)
            begin
                // well-formed palindrome of up to nine digits
                len = $urandom_range(1, 9);
                for (k = 0; k < len; k++)
                    digs[k] = (k == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9);
                acc = 0;
                for (k = 0; k < len; k++)
                    acc = acc * 10 + digs[(k < (len + 1) / 2) ? k : len - 1 - k];
                val = VALUE_W'(acc);
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 5))
                    0: val = 0;
                    1: val = 1;
                    2: val = -1;
                    3: val = VALUE_MAX;
                    4: val = VALUE_MIN;
                    default: val = 1_000_000_000;
                endcase
            end
            else
            begin
                val = $urandom();
            end
            // trial division is slow on big operands, so most prime tests stay small
            if (mode == MODE_PRIME && val > 4095)
                val = ($urandom_range(0, 19) == 0) ? val % 65536 : val % 4096;
            queue_operand(mode, val);
        end

        while (operands_pending.size() > 0 || outcomes_due.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        // catch any stray result after the last one expected
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operands: parity %0d, prime %0d, palindrome %0d, sign %0d",
                 operands_sent, mode_counts[0], mode_counts[1], mode_counts[2],
                 mode_counts[3]);
        $display("reverse %0d, digit sum %0d, invalid %0d, results checked %0d",
                 mode_counts[4], mode_counts[5], mode_counts[6] + mode_counts[7],
                 outcomes_seen);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #120_000_000;
        $display("timeout with %0d results still expected", outcomes_due.size());
        $display("tb failed");
        $finish;
    end

endmodule

[decimal_number_property_unit.f]
rtl/core/dnpu_pkg.sv
rtl/core/dnpu_divider.sv
rtl/core/decimal_number_property_unit.sv
verif/tb.sv
